FILE: sv/dsl_pkg.sv
// Shared types and helpers for the double-step line rasteriser.
// No dependencies; imported by every module of the block.
package dsl_pkg;

    localparam int MAX_CW = 16;

    // Item kinds carried on the input tuser
    localparam logic KIND_NEW_LINE = 1'b0;
    localparam logic KIND_STEP     = 1'b1;

    // Line control flags kept between requests
    typedef struct packed {
        logic line_active;
        logic major_is_y;
        logic steep_case;
        logic dir_x_neg;
        logic dir_y_neg;
    } t_flags;

    // Move a coordinate by k pixels, backwards when neg is set (modular)
    function automatic logic [MAX_CW-1:0] coord_off(input logic [MAX_CW-1:0] c,
                                                    input logic [1:0] k,
                                                    input logic neg);
        logic [MAX_CW-1:0] kk;
        kk = {{(MAX_CW-2){1'b0}}, k};
        return neg ? c - kk : c + kk;
    endfunction

endpackage

FILE: sv/dsl_setup.sv
// New-line set-up: deltas, axis choice, decision terms and group counts.
// Depends on dsl_pkg.
module dsl_setup import dsl_pkg::*; #(
    parameter int CW = 12,
    parameter int DW = CW + 6
) (
    input  logic [CW-1:0]        i_sx,
    input  logic [CW-1:0]        i_sy,
    input  logic [CW-1:0]        i_ex,
    input  logic [CW-1:0]        i_ey,
    output t_flags               o_flags,
    output logic signed [DW-1:0] o_dec,
    output logic signed [DW-1:0] o_c,
    output logic signed [DW-1:0] o_inc1,
    output logic signed [DW-1:0] o_inc2,
    output logic [CW-3:0]        o_groups,
    output logic [1:0]           o_tail,
    output logic [2:0]           o_count,
    output logic                 o_done
);
    logic signed [CW:0]   dx, dy;
    logic [CW-1:0]        adx, ady, dmaj, dmin, dm1;
    logic                 myy, active;
    logic signed [DW-1:0] smaj, smin, inc2, c;

    // Absolute deltas and major axis (ties go to y)
    always_comb begin
        dx    = $signed({1'b0, i_ex}) - $signed({1'b0, i_sx});
        dy    = $signed({1'b0, i_ey}) - $signed({1'b0, i_sy});
        adx   = dx[CW] ? CW'(-dx) : dx[CW-1:0];
        ady   = dy[CW] ? CW'(-dy) : dy[CW-1:0];
        myy   = !(adx > ady);
        dmaj  = myy ? ady : adx;
        dmin  = myy ? adx : ady;
        dm1   = dmaj - CW'(1);
        smaj  = $signed(DW'(dmaj));
        smin  = $signed(DW'(dmin));
        inc2  = (smin <<< 2) - (smaj <<< 1);
        c     = (inc2 >= 0) ? ((smin - smaj) <<< 1) : (smin <<< 1);
        active = dmaj > CW'(1);

        o_flags.line_active = active;
        o_flags.major_is_y  = myy;
        o_flags.steep_case  = inc2 >= 0;
        o_flags.dir_x_neg   = dx[CW];
        o_flags.dir_y_neg   = dy[CW];
        o_c      = c;
        o_inc1   = c <<< 1;
        o_inc2   = inc2;
        o_dec    = (inc2 >= 0) ? (c <<< 1) + smaj : (c <<< 1) - smaj;
        o_groups = (dmaj != '0) ? dm1[CW-1:2] : '0;
        o_tail   = (dmaj != '0) ? dm1[1:0] : 2'd0;
        o_count  = (dmaj == '0 && dmin == '0) ? 3'd1 : 3'd2;
        o_done   = !active;
    end
endmodule

FILE: sv/dsl_step.sv
// One double-step iteration from both ends, including the closing tail group.
// Depends on dsl_pkg.
module dsl_step import dsl_pkg::*; #(
    parameter int CW = 12,
    parameter int DW = CW + 6
) (
    input  t_flags               i_flags,
    input  logic [CW-1:0]        i_near_x,
    input  logic [CW-1:0]        i_near_y,
    input  logic [CW-1:0]        i_far_x,
    input  logic [CW-1:0]        i_far_y,
    input  logic signed [DW-1:0] i_dec,
    input  logic signed [DW-1:0] i_c,
    input  logic signed [DW-1:0] i_inc1,
    input  logic signed [DW-1:0] i_inc2,
    input  logic [CW-3:0]        i_groups,
    input  logic [1:0]           i_tail,
    output t_flags               o_flags,
    output logic [CW-1:0]        o_near_x,
    output logic [CW-1:0]        o_near_y,
    output logic [CW-1:0]        o_far_x,
    output logic [CW-1:0]        o_far_y,
    output logic signed [DW-1:0] o_dec,
    output logic [CW-3:0]        o_groups,
    output logic [1:0]           o_tail,
    output logic [CW-1:0]        o_px [4],
    output logic [CW-1:0]        o_py [4],
    output logic [2:0]           o_count,
    output logic                 o_done
);
    logic [CW-1:0] a_mj, a_mn, b_mj, b_mn;
    logic [CW-1:0] q_mj [4];
    logic [CW-1:0] q_mn [4];
    logic          s_mj, s_mn, myy, steep;
    logic          c_a, c_b, c_lt, c_gt;
    logic [1:0]    k1, k2;
    logic          m1, m2, m3;

    always_comb begin
        myy  = i_flags.major_is_y;
        steep = i_flags.steep_case;
        a_mj = myy ? i_near_y : i_near_x;
        a_mn = myy ? i_near_x : i_near_y;
        b_mj = myy ? i_far_y : i_far_x;
        b_mn = myy ? i_far_x : i_far_y;
        s_mj = myy ? i_flags.dir_y_neg : i_flags.dir_x_neg;
        s_mn = myy ? i_flags.dir_x_neg : i_flags.dir_y_neg;
        c_a  = !steep && i_dec < 0;
        c_b  = steep && i_dec > 0;
        c_lt = i_dec < i_c;
        c_gt = i_dec > i_c;

        // Minor-axis offsets of the two pixels on each side
        if (c_a) begin
            k1 = 2'd0; k2 = 2'd0; m1 = 1'b0; m2 = 1'b0; m3 = 1'b0;
        end else if (c_b) begin
            k1 = 2'd1; k2 = 2'd2; m1 = 1'b1; m2 = 1'b1; m3 = 1'b1;
        end else if (c_lt) begin
            k1 = 2'd0; k2 = 2'd1; m1 = 1'b0; m2 = 1'b1; m3 = 1'b0;
        end else begin
            k1 = 2'd1; k2 = 2'd1; m1 = 1'b1; m2 = 1'b0; m3 = steep ? c_gt : 1'b1;
        end
        if (i_groups == '0) begin
            k1 = {1'b0, m1};
            k2 = {1'b0, m1} + {1'b0, m2};
            q_mn[2] = CW'(coord_off(MAX_CW'(b_mn), {1'b0, m3}, !s_mn));
        end else begin
            q_mn[2] = CW'(coord_off(MAX_CW'(b_mn), k1, !s_mn));
        end
        q_mj[0] = CW'(coord_off(MAX_CW'(a_mj), 2'd1, s_mj));
        q_mj[1] = CW'(coord_off(MAX_CW'(a_mj), 2'd2, s_mj));
        q_mj[2] = CW'(coord_off(MAX_CW'(b_mj), 2'd1, !s_mj));
        q_mj[3] = CW'(coord_off(MAX_CW'(b_mj), 2'd2, !s_mj));
        q_mn[0] = CW'(coord_off(MAX_CW'(a_mn), k1, s_mn));
        q_mn[1] = CW'(coord_off(MAX_CW'(a_mn), k2, s_mn));
        q_mn[3] = CW'(coord_off(MAX_CW'(b_mn), k2, !s_mn));

        // Defaults: hold everything, emit nothing
        o_flags  = i_flags;
        o_near_x = i_near_x;
        o_near_y = i_near_y;
        o_far_x  = i_far_x;
        o_far_y  = i_far_y;
        o_dec    = i_dec;
        o_groups = i_groups;
        o_tail   = i_tail;
        o_count  = 3'd0;
        o_done   = 1'b0;
        for (int i = 0; i < 4; i++) begin
            o_px[i] = '0;
            o_py[i] = '0;
        end

        if (i_flags.line_active) begin
            if (i_groups != '0) begin
                o_count  = 3'd4;
                o_dec    = i_dec + ((c_a || c_b) ? i_inc1 : i_inc2);
                o_groups = i_groups - (CW-2)'(1);
                if (i_groups == (CW-2)'(1) && i_tail == 2'd0) begin
                    o_flags.line_active = 1'b0;
                    o_done = 1'b1;
                end
                for (int i = 0; i < 4; i++) begin
                    o_px[i] = myy ? q_mn[i] : q_mj[i];
                    o_py[i] = myy ? q_mj[i] : q_mn[i];
                end
                o_near_x = o_px[1];
                o_near_y = o_py[1];
                o_far_x  = o_px[3];
                o_far_y  = o_py[3];
            end else begin
                o_count = {1'b0, i_tail};
                o_tail  = 2'd0;
                o_flags.line_active = 1'b0;
                o_done  = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < i_tail) begin
                        o_px[i] = myy ? q_mn[i] : q_mj[i];
                        o_py[i] = myy ? q_mj[i] : q_mn[i];
                    end
                end
                o_near_x = (i_tail > 2'd1) ? o_px[1] : o_px[0];
                o_near_y = (i_tail > 2'd1) ? o_py[1] : o_py[0];
                if (i_tail > 2'd2) begin
                    o_far_x = o_px[2];
                    o_far_y = o_py[2];
                end
            end
        end
    end
endmodule

FILE: sv/double_step_line_rasterizer.sv
// Double-step line rasteriser: input register, one set-up or step pass, result register.
// Depends on dsl_pkg, dsl_setup and dsl_step.
//
// A new-line request (tuser 0) loads the end points and colour and returns them
// as a group of two pixels (one for a zero-length line). Each step request
// (tuser 1) returns the next group of four pixels, two from each end; the last
// group carries the one to three tail pixels (four if no tail) and raises tlast.
// A step with no line in progress returns an empty group. One request is taken per
// cycle unless the output stalls; it passes the input register, then the result
// register; line state updates in the same pass, so requests may follow back to back.
module double_step_line_rasterizer import dsl_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // start_x, start_y, end_x, end_y, color (from bit 0 up), zero padded
    input  logic [((4*COORD_BITS+24+7)/8)*8-1:0] i_s_tdata,
    // kind
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // pixel0_x, pixel0_y .. pixel3_x, pixel3_y, pixel_count, pixel_color, zero padded
    output logic [((8*COORD_BITS+27+7)/8)*8-1:0] o_m_tdata,
    // line_done
    output logic                 o_m_tlast
);
    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 6;
    localparam int OW  = ((8*CW+27+7)/8)*8;

    logic          r_in_valid, r_kind, advance;
    logic [CW-1:0] r_sx, r_sy, r_ex, r_ey;
    logic [23:0]   r_in_color;

    t_flags               r_flags, su_flags, st_flags;
    logic [CW-1:0]        r_near_x, r_near_y, r_far_x, r_far_y;
    logic signed [DW-1:0] r_dec, r_c, r_inc1, r_inc2;
    logic [CW-3:0]        r_groups;
    logic [1:0]           r_tail;
    logic [23:0]          r_color;

    logic signed [DW-1:0] su_dec, su_c, su_inc1, su_inc2, st_dec;
    logic [CW-3:0]        su_groups, st_groups;
    logic [1:0]           su_tail, st_tail;
    logic [2:0]           su_count, st_count;
    logic                 su_done, st_done;
    logic [CW-1:0]        st_near_x, st_near_y, st_far_x, st_far_y;
    logic [CW-1:0]        st_px [4];
    logic [CW-1:0]        st_py [4];

    logic                 r_out_valid, r_out_last;
    logic [OW-1:0]        r_out_data, n_out_data;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    dsl_setup #(.CW(CW), .DW(DW)) u_setup (
        .i_sx(r_sx), .i_sy(r_sy), .i_ex(r_ex), .i_ey(r_ey),
        .o_flags(su_flags), .o_dec(su_dec), .o_c(su_c), .o_inc1(su_inc1),
        .o_inc2(su_inc2), .o_groups(su_groups), .o_tail(su_tail),
        .o_count(su_count), .o_done(su_done)
    );

    dsl_step #(.CW(CW), .DW(DW)) u_step (
        .i_flags(r_flags), .i_near_x(r_near_x), .i_near_y(r_near_y),
        .i_far_x(r_far_x), .i_far_y(r_far_y), .i_dec(r_dec), .i_c(r_c),
        .i_inc1(r_inc1), .i_inc2(r_inc2), .i_groups(r_groups), .i_tail(r_tail),
        .o_flags(st_flags), .o_near_x(st_near_x), .o_near_y(st_near_y),
        .o_far_x(st_far_x), .o_far_y(st_far_y), .o_dec(st_dec),
        .o_groups(st_groups), .o_tail(st_tail), .o_px(st_px), .o_py(st_py),
        .o_count(st_count), .o_done(st_done)
    );

    // Pack the result word
    always_comb begin
        n_out_data = '0;
        if (r_kind == KIND_NEW_LINE) begin
            n_out_data[CW-1:0]    = r_sx;
            n_out_data[2*CW-1:CW] = r_sy;
            if (su_count == 3'd2) begin
                n_out_data[3*CW-1:2*CW] = r_ex;
                n_out_data[4*CW-1:3*CW] = r_ey;
            end
            n_out_data[8*CW+2:8*CW]   = su_count;
            n_out_data[8*CW+26:8*CW+3] = r_in_color;
        end else begin
            for (int i = 0; i < 4; i++) begin
                n_out_data[(2*i)*CW +: CW]   = st_px[i];
                n_out_data[(2*i+1)*CW +: CW] = st_py[i];
            end
            n_out_data[8*CW+2:8*CW]   = st_count;
            n_out_data[8*CW+26:8*CW+3] = r_color;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_kind     <= i_s_tuser;
            r_sx       <= i_s_tdata[CW-1:0];
            r_sy       <= i_s_tdata[2*CW-1:CW];
            r_ex       <= i_s_tdata[3*CW-1:2*CW];
            r_ey       <= i_s_tdata[4*CW-1:3*CW];
            r_in_color <= i_s_tdata[4*CW+23:4*CW];
        end
    end

    // Line state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_flags     <= '0;
            r_near_x    <= '0;
            r_near_y    <= '0;
            r_far_x     <= '0;
            r_far_y     <= '0;
            r_dec       <= '0;
            r_c         <= '0;
            r_inc1      <= '0;
            r_inc2      <= '0;
            r_groups    <= '0;
            r_tail      <= '0;
            r_color     <= '0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_out_data  <= n_out_data;
            if (r_kind == KIND_NEW_LINE) begin
                r_out_last <= su_done;
                r_flags    <= su_flags;
                r_near_x   <= r_sx;
                r_near_y   <= r_sy;
                r_far_x    <= r_ex;
                r_far_y    <= r_ey;
                r_dec      <= su_dec;
                r_c        <= su_c;
                r_inc1     <= su_inc1;
                r_inc2     <= su_inc2;
                r_groups   <= su_groups;
                r_tail     <= su_tail;
                r_color    <= r_in_color;
            end else begin
                r_out_last <= st_done;
                r_flags    <= st_flags;
                r_near_x   <= st_near_x;
                r_near_y   <= st_near_y;
                r_far_x    <= st_far_x;
                r_far_y    <= st_far_y;
                r_dec      <= st_dec;
                r_groups   <= st_groups;
                r_tail     <= st_tail;
            end
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Groups remain only while a line is in progress
    a_groups_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_groups != '0) |-> r_flags.line_active)
        else $error("groups left with no active line");

    // A step with no line in progress gives an empty, unfinished group
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_kind == KIND_STEP && !r_flags.line_active)
        |=> (o_m_tdata[8*CW+2:8*CW] == 3'd0 && !o_m_tlast))
        else $error("idle step produced pixels");

    // A zero-length line finishes at once with a single pixel
    a_zero_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_kind == KIND_NEW_LINE && r_sx == r_ex && r_sy == r_ey)
        |=> (o_m_tlast && o_m_tdata[8*CW+2:8*CW] == 3'd1))
        else $error("zero-length line not closed with one pixel");
endmodule
